[design/dvbe_pkg.sv]
`default_nettype none

package dvbe_pkg;

  // Default number of 7-bit groups in one code.
  localparam int unsigned NumGroupsDefault = 4;

  localparam int unsigned IdWidth    = 28;
  localparam int unsigned GroupWidth = 7;
  localparam int unsigned ByteWidth  = 8;

  // Continuation flag, set on every byte of a code but the last.
  localparam logic [ByteWidth-1:0] ContFlag = 8'h80;

  typedef struct packed {
    logic [IdWidth-1:0] term_id;
    logic               list_start;
  } in_item_t;

  typedef struct packed {
    logic [ByteWidth-1:0] code_byte;
    logic                 last_byte;
  } out_item_t;

endpackage

`default_nettype wire

[design/dedup_delta_varbyte_encoder.sv]
`default_nettype none

// Delta variable-byte encoder with duplicate removal. Each input word carries a term id
// of a sorted list and a list_start flag. An id equal to the previously kept id (and not
// flagged as list start) is dropped and produces no output; otherwise the gap from the
// previously kept id (the id itself at list start, wrapping modulo 2^28 on unsorted input)
// is sent as one to NUM_GROUPS output words, one code byte each: 7-bit groups, most
// significant first, leading zero groups skipped, bit 7 set on all bytes but the last,
// which is also flagged by last_byte. Gaps are truncated to 7*NUM_GROUPS bits. An input
// word is accepted in any cycle in which the one-entry input stage is free or is about to
// hand its item on, so the block takes a new id while the bytes of the previous one are
// still leaving. The output port moves one byte per cycle while out_ready_i is high; a
// kept id sends 1 to NUM_GROUPS bytes (at most 4 with the default setting), and a dropped
// id takes an input word but sends no byte. The first byte of an item is registered in
// the input stage and then in the output stage before it is on the output.

module dedup_delta_varbyte_encoder #(
  parameter int unsigned NUM_GROUPS = dvbe_pkg::NumGroupsDefault
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  input  wire dvbe_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire                      out_ready_i,
  output dvbe_pkg::out_item_t      out_item_o
);

  localparam int unsigned GapWidth = dvbe_pkg::GroupWidth * NUM_GROUPS;
  localparam int unsigned IdxWidth = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

  typedef logic [NUM_GROUPS-1:0][dvbe_pkg::GroupWidth-1:0] groups_t;

  // Last kept id.
  logic [dvbe_pkg::IdWidth-1:0] prev_id_q, prev_id_d;

  // Input stage: the gap of an accepted, kept id and the index of its top group.
  logic                in_valid_q, in_valid_d;
  groups_t             in_gap_q, in_gap_d;
  logic [IdxWidth-1:0] in_top_q, in_top_d;

  // Output stage: the gap being sent and the index of the group now on the port.
  logic                out_valid_q, out_valid_d;
  groups_t             out_gap_q, out_gap_d;
  logic [IdxWidth-1:0] out_idx_q, out_idx_d;

  logic                                 in_fire;
  logic                                 keep;
  logic [dvbe_pkg::IdWidth-1:0]         gap_id;
  logic [dvbe_pkg::IdWidth+GapWidth-1:0] gap_ext;
  groups_t                              gap_new;
  logic [IdxWidth-1:0]                  top_new;
  logic                                 out_last;
  logic                                 out_fire;
  logic                                 out_free;
  logic                                 out_load;

  // The output stage frees up when its final byte leaves; the input stage moves on then.
  assign out_last   = (out_idx_q == '0);
  assign out_fire   = out_valid_q && out_ready_i;
  assign out_free   = !out_valid_q || (out_ready_i && out_last);
  assign out_load   = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_load;
  assign in_fire    = in_valid_i && in_ready_o;

  // A list start is always kept; otherwise a repeat of the last kept id is dropped.
  assign keep = in_item_i.list_start || (in_item_i.term_id != prev_id_q);

  // The gap wraps at the id width, then is zero-extended or truncated to the code width.
  assign gap_id  = in_item_i.list_start ? in_item_i.term_id
                                        : (in_item_i.term_id - prev_id_q);
  assign gap_ext = {{GapWidth{1'b0}}, gap_id};
  assign gap_new = groups_t'(gap_ext[GapWidth-1:0]);

  // Highest nonzero group; a zero gap still sends its lowest group.
  always_comb begin
    top_new = '0;
    for (int g = 1; g < int'(NUM_GROUPS); g++) begin
      if (gap_new[g] != '0) begin
        top_new = IdxWidth'(g);
      end
    end
  end

  always_comb begin
    prev_id_d = prev_id_q;
    if (in_fire && keep) begin
      prev_id_d = in_item_i.term_id;
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    in_gap_d   = in_gap_q;
    in_top_d   = in_top_q;
    if (out_load) begin
      in_valid_d = 1'b0;
    end
    if (in_fire && keep) begin
      in_valid_d = 1'b1;
      in_gap_d   = gap_new;
      in_top_d   = top_new;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_gap_d   = out_gap_q;
    out_idx_d   = out_idx_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_gap_d   = in_gap_q;
      out_idx_d   = in_top_q;
    end else if (out_fire) begin
      if (out_last) begin
        out_valid_d = 1'b0;
      end else begin
        out_idx_d = out_idx_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_id_q   <= '0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
    end else begin
      prev_id_q   <= prev_id_d;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      out_idx_q   <= out_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_gap_q  <= in_gap_d;
    in_top_q  <= in_top_d;
    out_gap_q <= out_gap_d;
  end

  assign out_valid_o          = out_valid_q;
  assign out_item_o.code_byte = {1'b0, out_gap_q[out_idx_q]}
                                | (out_last ? '0 : dvbe_pkg::ContFlag);
  assign out_item_o.last_byte = out_last;

endmodule

`default_nettype wire

[design/dvbe_checker.sv]
`default_nettype none

module dvbe_checker (
  input wire                      clk_i,
  input wire                      rst_ni,
  input wire                      in_valid_i,
  input wire                      in_ready_o,
  input wire dvbe_pkg::in_item_t  in_item_i,
  input wire                      out_valid_o,
  input wire                      out_ready_i,
  input wire dvbe_pkg::out_item_t out_item_o
);

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("output word changed while stalled");

  // The continuation flag is set exactly on bytes that are not the last.
  a_cont_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.code_byte[7] == !out_item_o.last_byte))
    else $error("continuation flag does not match last_byte");

  // After a non-final byte leaves, the rest of that code is ready at once.
  a_code_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_item_o.last_byte |=> out_valid_o)
    else $error("gap inside a code");

  // Input is held back only while results are waiting on the output.
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no output pending");

endmodule

bind dedup_delta_varbyte_encoder dvbe_checker u_dvbe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire
